### rtl/agc_pkg.sv
package agc_pkg;

    localparam int SUM_W       = 32;
    localparam int HALF_W      = SUM_W / 2;
    localparam int DIV_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int ROOT_REM_W  = 10;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES  = HALF_W / STEPS_PER_STAGE;
    // stage 0 setup, divide stages, two root stages
    localparam int NUM_STAGES  = 1 + DIV_STAGES + 2;
    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
    localparam logic [DIV_W-1:0]  COUNT_RESET = DIV_W'(1);

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [HALF_W-1:0] qd;   // dividend bits shift out, quotient bits shift in
        logic              ovf;
    } div_state_t;

    typedef struct packed {
        logic [HALF_W-1:0]     q;
        logic [ROOT_REM_W-1:0] rem;
        logic [BYTE_W-1:0]     root;
        logic                  ovf;
    } root_state_t;

    // one restoring divide step, remainder stays below the divisor
    function automatic div_state_t div_step(div_state_t st, logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic [DIV_W:0] diff;
        div_state_t     r;
        t    = {st.rem, st.qd[HALF_W-1]};
        diff = t - {1'b0, d};
        r    = st;
        r.qd = {st.qd[HALF_W-2:0], ~diff[DIV_W]};
        if (!diff[DIV_W])
        begin
            r.rem = diff[DIV_W-1:0];
        end
        else
        begin
            r.rem = t[DIV_W-1:0];
        end
        return r;
    endfunction

    // one digit of the integer square root, two radicand bits per step
    function automatic root_state_t root_step(root_state_t st);
        logic [ROOT_REM_W+1:0] r2;
        logic [ROOT_REM_W+1:0] trial;
        logic [ROOT_REM_W+2:0] diff;
        logic                  ge;
        root_state_t           r;
        r2    = {st.rem, st.q[HALF_W-1:HALF_W-2]};
        trial = {2'b00, st.root, 2'b01};
        diff  = {1'b0, r2} - {1'b0, trial};
        ge    = ~diff[ROOT_REM_W+2];
        r      = st;
        r.q    = {st.q[HALF_W-3:0], 2'b00};
        r.root = {st.root[BYTE_W-2:0], ge};
        if (ge)
        begin
            r.rem = diff[ROOT_REM_W-1:0];
        end
        else
        begin
            r.rem = r2[ROOT_REM_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/agc_chan.sv
module agc_chan (
    input  logic                           clk,
    input  logic [agc_pkg::NUM_STAGES-1:0] adv,
    input  logic [agc_pkg::SUM_W-1:0]      sum,
    input  logic [agc_pkg::DIV_W-1:0]      divisor,
    output logic [agc_pkg::BYTE_W-1:0]     byte_out
);

    localparam int ROOT0 = agc_pkg::DIV_STAGES + 1;
    localparam int LAST  = agc_pkg::NUM_STAGES - 1;

    agc_pkg::div_state_t  div_reg  [0:agc_pkg::DIV_STAGES];
    agc_pkg::div_state_t  div_next [0:agc_pkg::DIV_STAGES];
    agc_pkg::root_state_t root_reg;
    agc_pkg::root_state_t root_next;
    logic [agc_pkg::BYTE_W-1:0] byte_reg;
    logic [agc_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        agc_pkg::div_state_t  ds;
        agc_pkg::root_state_t rs;
        // quotient of 65536 or more saturates, so only 16 quotient bits are built
        div_next[0].ovf = (sum[agc_pkg::SUM_W-1:agc_pkg::HALF_W] >= divisor);
        div_next[0].rem = sum[agc_pkg::SUM_W-1:agc_pkg::HALF_W];
        div_next[0].qd  = sum[agc_pkg::HALF_W-1:0];
        for (int s = 1; s <= agc_pkg::DIV_STAGES; s++)
        begin
            ds = div_reg[s-1];
            for (int k = 0; k < agc_pkg::STEPS_PER_STAGE; k++)
            begin
                ds = agc_pkg::div_step(ds, divisor);
            end
            div_next[s] = ds;
        end

        rs.q    = div_reg[agc_pkg::DIV_STAGES].qd;
        rs.rem  = '0;
        rs.root = '0;
        rs.ovf  = div_reg[agc_pkg::DIV_STAGES].ovf;
        for (int k = 0; k < agc_pkg::STEPS_PER_STAGE; k++)
        begin
            rs = agc_pkg::root_step(rs);
        end
        root_next = rs;

        rs = root_reg;
        for (int k = 0; k < agc_pkg::STEPS_PER_STAGE; k++)
        begin
            rs = agc_pkg::root_step(rs);
        end
        byte_next = rs.ovf ? agc_pkg::BYTE_MAX : rs.root;
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= agc_pkg::DIV_STAGES; s++)
        begin
            if (adv[s])
            begin
                div_reg[s] <= div_next[s];
            end
        end
        if (adv[ROOT0])
        begin
            root_reg <= root_next;
        end
        if (adv[LAST])
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

### rtl/averaged_gamma_color_to_rgb8.sv
// channel | signals                                        | handshake
// in      | acc_red, acc_green, acc_blue, frame_end_in     | in_valid / in_ready
// out     | red_byte, green_byte, blue_byte, frame_end_out | out_valid / out_ready
// config  | cfg_data (sample_count)                        | cfg_we, no wait
//
// stages: setup, four divide stages of four quotient bits each,
// two square-root stages of four root bits each; one item per clock sustained while out_ready holds.
// rst_n clears the stage valid bits and sets sample_count to 1.
// a stall at the output holds each full stage with no empty stage after it; the others keep moving.
module averaged_gamma_color_to_rgb8 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [agc_pkg::DIV_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [agc_pkg::SUM_W-1:0]    acc_red,
    input  logic [agc_pkg::SUM_W-1:0]    acc_green,
    input  logic [agc_pkg::SUM_W-1:0]    acc_blue,
    input  logic                         frame_end_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [agc_pkg::BYTE_W-1:0]   red_byte,
    output logic [agc_pkg::BYTE_W-1:0]   green_byte,
    output logic [agc_pkg::BYTE_W-1:0]   blue_byte,
    output logic                         frame_end_out
);

    localparam int NS = agc_pkg::NUM_STAGES;

    logic [agc_pkg::DIV_W-1:0] divisor_reg;
    logic [NS-1:0]             valid_reg;
    logic [NS-1:0]             valid_next;
    logic [NS-1:0]             fe_reg;
    logic [NS-1:0]             rdy;
    logic [NS-1:0]             adv;
    logic [NS-1:0]             up_valid;
    logic [NS-1:0]             fe_up;

    // a zero count acts as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= agc_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            divisor_reg <= (cfg_data == '0) ? agc_pkg::COUNT_RESET : cfg_data;
        end
    end

    always_comb
    begin
        up_valid = {valid_reg[NS-2:0], in_valid};
        fe_up    = {fe_reg[NS-2:0], frame_end_in};
        rdy[NS-1] = ~valid_reg[NS-1] | out_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            rdy[s] = ~valid_reg[s] | rdy[s+1];
        end
        adv        = rdy & up_valid;
        valid_next = valid_reg;
        for (int s = 0; s < NS; s++)
        begin
            if (rdy[s])
            begin
                valid_next[s] = up_valid[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            if (adv[s])
            begin
                fe_reg[s] <= fe_up[s];
            end
        end
    end

    agc_chan u_red (
        .clk      (clk),
        .adv      (adv),
        .sum      (acc_red),
        .divisor  (divisor_reg),
        .byte_out (red_byte)
    );

    agc_chan u_green (
        .clk      (clk),
        .adv      (adv),
        .sum      (acc_green),
        .divisor  (divisor_reg),
        .byte_out (green_byte)
    );

    agc_chan u_blue (
        .clk      (clk),
        .adv      (adv),
        .sum      (acc_blue),
        .divisor  (divisor_reg),
        .byte_out (blue_byte)
    );

    assign in_ready      = rdy[0];
    assign out_valid     = valid_reg[NS-1];
    assign frame_end_out = fe_reg[NS-1];

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted item did not enter stage 0");

    a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !rdy[4]) |=> (valid_reg[3] && $stable(fe_reg[3])))
        else $error("stalled stage lost its item");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_reg != '0)
        else $error("divisor register holds zero");

endmodule

### dv/averaged_gamma_color_to_rgb8_test.sv
`timescale 1ns / 100ps

module averaged_gamma_color_to_rgb8_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          ITEMS_PER_PHASE = 162;
    localparam int          NUM_PHASES = 12;

    typedef struct packed {
        logic [agc_pkg::BYTE_W-1:0] red;
        logic [agc_pkg::BYTE_W-1:0] green;
        logic [agc_pkg::BYTE_W-1:0] blue;
        logic                       frame_end;
    } pixel_bytes_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [agc_pkg::DIV_W-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [agc_pkg::SUM_W-1:0]  acc_red;
    logic [agc_pkg::SUM_W-1:0]  acc_green;
    logic [agc_pkg::SUM_W-1:0]  acc_blue;
    logic                       frame_end_in;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [agc_pkg::BYTE_W-1:0] red_byte;
    logic [agc_pkg::BYTE_W-1:0] green_byte;
    logic [agc_pkg::BYTE_W-1:0] blue_byte;
    logic                       frame_end_out;

    pixel_bytes_t               expected_pixels[$];
    logic [agc_pkg::DIV_W-1:0]  model_count;
    int                         send_idle_pct;
    int                         rx_stall_pct;
    int                         errors = 0;
    int unsigned                cycles = 0;

    averaged_gamma_color_to_rgb8 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .acc_red       (acc_red),
        .acc_green     (acc_green),
        .acc_blue      (acc_blue),
        .frame_end_in  (frame_end_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_byte      (red_byte),
        .green_byte    (green_byte),
        .blue_byte     (blue_byte),
        .frame_end_out (frame_end_out)
    );

    always #2 clk = ~clk;

    // average, integer square root, saturate at 255
    function automatic logic [agc_pkg::BYTE_W-1:0] gamma_byte(
        logic [agc_pkg::SUM_W-1:0] sum,
        logic [agc_pkg::DIV_W-1:0] count);
        logic [31:0] divisor;
        logic [31:0] quot;
        logic [31:0] root;
        logic [31:0] trial;
        divisor = (count == '0) ? 32'd1 : {16'd0, count};
        quot    = sum / divisor;
        if (quot >= 32'd65536)
        begin
            return agc_pkg::BYTE_MAX;
        end
        root = '0;
        for (int b = agc_pkg::BYTE_W - 1; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= quot)
            begin
                root = trial;
            end
        end
        return root[agc_pkg::BYTE_W-1:0];
    endfunction

    function automatic pixel_bytes_t predict_pixel(logic [agc_pkg::SUM_W-1:0] r,
                                                   logic [agc_pkg::SUM_W-1:0] g,
                                                   logic [agc_pkg::SUM_W-1:0] b,
                                                   logic fe,
                                                   logic [agc_pkg::DIV_W-1:0] count);
        pixel_bytes_t p;
        p.red       = gamma_byte(r, count);
        p.green     = gamma_byte(g, count);
        p.blue      = gamma_byte(b, count);
        p.frame_end = fe;
        return p;
    endfunction

    // sums whose average lands on a root value or its square boundaries, near the overflow bound, or anywhere
    function automatic logic [agc_pkg::SUM_W-1:0] pick_sum(logic [agc_pkg::DIV_W-1:0] count);
        logic [63:0] divisor;
        logic [63:0] quot;
        logic [63:0] sum;
        int unsigned r;
        divisor = (count == '0) ? 64'd1 : {48'd0, count};
        case ($urandom_range(0, 9))
            0, 1:
            begin
                return $urandom();
            end
            2:
            begin
                quot = 64'($urandom_range(64900, 65700));
            end
            default:
            begin
                r    = $urandom_range(0, 255);
                quot = 64'(r * r + $urandom_range(0, 2 * r + 1));
            end
        endcase
        sum = quot * divisor + 64'($urandom_range(0, 32'(divisor - 64'd1)));
        if (sum > 64'hFFFF_FFFF)
        begin
            return $urandom();
        end
        return sum[agc_pkg::SUM_W-1:0];
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic send_pixel(input logic [agc_pkg::SUM_W-1:0] r,
                              input logic [agc_pkg::SUM_W-1:0] g,
                              input logic [agc_pkg::SUM_W-1:0] b, input logic fe);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        acc_red      <= r;
        acc_green    <= g;
        acc_blue     <= b;
        frame_end_in <= fe;
        taken = 1'b0;
        while (!taken)
        begin
            // inputs only move at the rising edge, so the negedge view is final
            @(negedge clk);
            taken = in_ready;
            if (taken)
            begin
                expected_pixels.push_back(predict_pixel(r, g, b, fe, model_count));
            end
            @(posedge clk);
        end
    endtask

    task automatic set_sample_count(input logic [agc_pkg::DIV_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_count = value;
    endtask

    task automatic test_reset_count();
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0);
        send_pixel(32'h0000_FE01, 32'h0000_FE00, 32'h0001_0000, 1'b1);
        send_pixel(32'h0000_0001, 32'h0000_0003, 32'h0000_0004, 1'b0);
        send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FF00, 1'b0);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1);
        send_pixel(32'h0000_3FFF, 32'h0000_4000, 32'h0000_0008, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    endtask

    // zero count divides by one
    task automatic test_zero_count();
        set_sample_count('0);
        send_pixel(32'h0000_FE00, 32'h0000_0010, 32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0003, 32'h0000_FE01, 32'h0000_0000, 1'b0);
        send_pixel(32'h0001_0000, 32'h0000_FFFF, 32'h0000_00FF, 1'b1);
    endtask

    task automatic test_max_count();
        set_sample_count('1);
        send_pixel(32'hFFFF_FFFF, 32'hFFFE_FFFF, 32'hFFFE_0001, 1'b0);
        send_pixel(32'hFE00_01FF, 32'hFE00_01FE, 32'h0000_FFFE, 1'b1);
        send_pixel(32'h0000_FFFF, 32'h0000_0000, 32'h0003_FFFC, 1'b0);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_FFFE, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [agc_pkg::DIV_W-1:0] counts [NUM_PHASES];
        logic [agc_pkg::DIV_W-1:0] count;
        counts = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd3, 16'd17, 16'd256, 16'd4097,
                   16'd0, 16'd0, 16'hFFFE, 16'd1};
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            count = counts[ph];
            if (ph == 8 || ph == 9)
            begin
                count = 16'($urandom_range(1, 65535));
            end
            set_sample_count(count);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    rx_stall_pct  = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    rx_stall_pct  = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rx_stall_pct  = 80;
                end
                default:
                begin
                    send_idle_pct = 35;
                    rx_stall_pct  = 35;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_pixel(pick_sum(count), pick_sum(count), pick_sum(count),
                           1'($urandom_range(0, 1)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // result check, compared against the oldest expected pixel
    always @(negedge clk)
    begin
        pixel_bytes_t got;
        pixel_bytes_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{red_byte, green_byte, blue_byte, frame_end_out};
            if (expected_pixels.size() == 0)
            begin
                note_error($sformatf("unexpected pixel r=%0d g=%0d b=%0d fe=%0b",
                                     got.red, got.green, got.blue, got.frame_end));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.frame_end !== want.frame_end)
                begin
                    note_error($sformatf(
                        "expected r=%0d g=%0d b=%0d fe=%0b got r=%0d g=%0d b=%0d fe=%0b",
                        want.red, want.green, want.blue, want.frame_end,
                        got.red, got.green, got.blue, got.frame_end));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        acc_red       = '0;
        acc_green     = '0;
        acc_blue      = '0;
        frame_end_in  = 1'b0;
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        model_count   = agc_pkg::COUNT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_zero_count();
        test_max_count();
        test_random_traffic();

        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
